>>> sv/vvu_pkg.sv
// vvu_pkg: shared types and constants of the version vector unit
// no dependencies; used by vvu_if.sv and version_vector_unit.sv
`default_nettype none

package vvu_pkg;

  localparam int unsigned CLOCK_W = 64;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned INDEX_SPAN = 1 << INDEX_W;
  localparam int unsigned NUM_DEVICES_DEFAULT = 16;

  typedef enum logic [1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_INCREMENT = 2'd1,
    CMD_READ      = 2'd2,
    CMD_COMPARE   = 2'd3
  } cmd_e;

  typedef logic [CLOCK_W-1:0] clock_t;
  typedef logic [INDEX_W-1:0] index_t;

endpackage

`default_nettype wire

>>> sv/vvu_if.sv
// vvu_req_if and vvu_rsp_if: valid/ready channels of the version vector unit
// depends on vvu_pkg
`default_nettype none

interface vvu_req_if;
  logic            valid;
  logic            ready;
  vvu_pkg::cmd_e   command;
  vvu_pkg::index_t device_index;
  vvu_pkg::clock_t clock_value;
  logic            last;

  modport source (output valid, command, device_index, clock_value, last, input ready);
  modport sink   (input valid, command, device_index, clock_value, last, output ready);
endinterface

interface vvu_rsp_if;
  logic            valid;
  logic            ready;
  vvu_pkg::clock_t read_value;
  logic            is_before;
  logic            is_after;
  logic            is_equal;

  modport source (output valid, read_value, is_before, is_after, is_equal, input ready);
  modport sink   (input valid, read_value, is_before, is_after, is_equal, output ready);
endinterface

`default_nettype wire

>>> sv/version_vector_unit.sv
// version_vector_unit: vector clock with one 64-bit counter per device
// depends on vvu_pkg and vvu_if
//
// Takes one request per cycle. A request reads the counter memory in the
// cycle it is accepted; the second stage then does the max, increment, read
// or compare on that counter and writes it back, forwarding the written value
// to a request right behind it on the same device. Read results and the
// result of a compare request flagged last go from the second stage into an
// output register, where they wait for the result handshake. While a result
// waits, requests that give no result keep flowing; a second request that
// gives a result holds in the second stage and stalls the input until the
// output register frees.
// The counters start at zero right after reset with no clearing pass: a
// valid bit per entry marks counters written since reset.
// Indices at or above NUM_DEVICES read as zero and ignore writes.
`default_nettype none

module version_vector_unit #(
  parameter int unsigned NUM_DEVICES = vvu_pkg::NUM_DEVICES_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  vvu_req_if.sink    req_i,
  vvu_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH =
    (NUM_DEVICES < vvu_pkg::INDEX_SPAN) ? NUM_DEVICES : vvu_pkg::INDEX_SPAN;
  localparam int unsigned AW = $clog2(DEPTH);

  typedef logic [AW-1:0] addr_t;

  vvu_pkg::clock_t mem [DEPTH];
  logic [DEPTH-1:0] entry_valid_q;

  logic            s1_valid_q;
  vvu_pkg::cmd_e   s1_cmd_q;
  addr_t           s1_addr_q;
  logic            s1_hit_q;
  vvu_pkg::clock_t s1_value_q;
  logic            s1_last_q;
  vvu_pkg::clock_t rdata_q;
  logic            fwd_q;
  vvu_pkg::clock_t fwd_data_q;

  logic local_all_le_q, local_some_lt_q, other_all_le_q, other_some_lt_q;
  logic local_all_le_d, local_some_lt_d, other_all_le_d, other_some_lt_d;

  logic            rsp_valid_q;
  vvu_pkg::clock_t rsp_read_value_q;
  logic            rsp_before_q, rsp_after_q, rsp_equal_q;

  addr_t           in_addr;
  logic            in_hit;
  logic            accept;
  vvu_pkg::clock_t loc;
  logic            loc_gt, loc_lt;
  logic            s1_result, s1_go, out_free;
  logic            wr_en;
  vvu_pkg::clock_t wr_data;

  assign in_addr = AW'(req_i.device_index);
  assign in_hit  = 32'(req_i.device_index) < 32'(DEPTH);

  always_comb begin
    if (!s1_hit_q) begin
      loc = '0;
    end else if (fwd_q) begin
      loc = fwd_data_q;
    end else if (entry_valid_q[s1_addr_q]) begin
      loc = rdata_q;
    end else begin
      loc = '0;
    end
  end

  assign loc_gt = loc > s1_value_q;
  assign loc_lt = loc < s1_value_q;

  assign s1_result = s1_valid_q && ((s1_cmd_q == vvu_pkg::CMD_READ) ||
                                    ((s1_cmd_q == vvu_pkg::CMD_COMPARE) && s1_last_q));
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign s1_go     = s1_valid_q && (!s1_result || out_free);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign accept    = req_i.valid && req_i.ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = loc + vvu_pkg::clock_t'(1);
    case (s1_cmd_q)
      vvu_pkg::CMD_UPDATE: begin
        wr_en   = s1_go && s1_hit_q && loc_lt;
        wr_data = s1_value_q;
      end
      vvu_pkg::CMD_INCREMENT: begin
        wr_en = s1_go && s1_hit_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign local_all_le_d  = local_all_le_q && !loc_gt;
  assign local_some_lt_d = local_some_lt_q || loc_lt;
  assign other_all_le_d  = other_all_le_q && !loc_lt;
  assign other_some_lt_d = other_some_lt_q || loc_gt;

  // counter memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= wr_data;
    end
    if (accept) begin
      rdata_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (wr_en) begin
      entry_valid_q[s1_addr_q] <= 1'b1;
    end
  end

  // second stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= req_i.command;
      s1_addr_q  <= in_addr;
      s1_hit_q   <= in_hit;
      s1_value_q <= req_i.clock_value;
      s1_last_q  <= req_i.last;
      fwd_q      <= wr_en && (s1_addr_q == in_addr);
      fwd_data_q <= wr_data;
    end
  end

  // compare run flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_all_le_q  <= 1'b1;
      local_some_lt_q <= 1'b0;
      other_all_le_q  <= 1'b1;
      other_some_lt_q <= 1'b0;
    end else if (s1_go && (s1_cmd_q == vvu_pkg::CMD_COMPARE)) begin
      if (s1_last_q) begin
        local_all_le_q  <= 1'b1;
        local_some_lt_q <= 1'b0;
        other_all_le_q  <= 1'b1;
        other_some_lt_q <= 1'b0;
      end else begin
        local_all_le_q  <= local_all_le_d;
        local_some_lt_q <= local_some_lt_d;
        other_all_le_q  <= other_all_le_d;
        other_some_lt_q <= other_some_lt_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_go && s1_result) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_result) begin
      if (s1_cmd_q == vvu_pkg::CMD_READ) begin
        rsp_read_value_q <= loc;
        rsp_before_q     <= 1'b0;
        rsp_after_q      <= 1'b0;
        rsp_equal_q      <= 1'b0;
      end else begin
        rsp_read_value_q <= '0;
        rsp_before_q     <= local_all_le_d && local_some_lt_d;
        rsp_after_q      <= other_all_le_d && other_some_lt_d;
        rsp_equal_q      <= local_all_le_d && other_all_le_d;
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rsp_read_value_q;
  assign rsp_o.is_before  = rsp_before_q;
  assign rsp_o.is_after   = rsp_after_q;
  assign rsp_o.is_equal   = rsp_equal_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking bench for version_vector_unit, drives requests and checks results
// against a shadow vector clock kept in the bench
// depends on vvu_pkg, vvu_if.sv and version_vector_unit.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_DEV = vvu_pkg::NUM_DEVICES_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    vvu_pkg::clock_t read_value;
    logic            is_before;
    logic            is_after;
    logic            is_equal;
  } vvu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vvu_req_if req ();
  vvu_rsp_if rsp ();

  version_vector_unit #(
    .NUM_DEVICES(NUM_DEV)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #6 clk_i = ~clk_i;

  // shadow vector clock and run flags
  vvu_pkg::clock_t shadow_clock [NUM_DEV];
  logic            local_all_le;
  logic            local_some_lt;
  logic            other_all_le;
  logic            other_some_lt;
  vvu_result_t     awaited_results [$];

  int unsigned num_requests;
  int unsigned num_errors = 0;
  int unsigned num_reads;
  int unsigned num_before;
  int unsigned num_after;
  int unsigned num_equal;
  int unsigned num_concurrent;
  int unsigned idle_cycles = 0;
  bit          req_idle_en;
  bit          rsp_idle_en;

  function automatic void vector_clock_step(vvu_pkg::cmd_e cmd, vvu_pkg::index_t idx,
                                            vvu_pkg::clock_t val, logic last);
    vvu_pkg::clock_t loc;
    vvu_result_t     res;
    loc = (idx < NUM_DEV) ? shadow_clock[idx] : '0;
    res = '0;
    case (cmd)
      vvu_pkg::CMD_UPDATE: begin
        if (idx < NUM_DEV && val > shadow_clock[idx]) shadow_clock[idx] = val;
      end
      vvu_pkg::CMD_INCREMENT: begin
        if (idx < NUM_DEV) shadow_clock[idx] = shadow_clock[idx] + 64'd1;
      end
      vvu_pkg::CMD_READ: begin
        res.read_value = loc;
        awaited_results.push_back(res);
        num_reads++;
      end
      default: begin
        if (loc > val) local_all_le = 1'b0;
        if (loc < val) local_some_lt = 1'b1;
        if (val > loc) other_all_le = 1'b0;
        if (val < loc) other_some_lt = 1'b1;
        if (last) begin
          res.is_before = local_all_le && local_some_lt;
          res.is_after  = other_all_le && other_some_lt;
          res.is_equal  = local_all_le && other_all_le;
          awaited_results.push_back(res);
          if (res.is_before) num_before++;
          else if (res.is_after) num_after++;
          else if (res.is_equal) num_equal++;
          else num_concurrent++;
          local_all_le  = 1'b1;
          local_some_lt = 1'b0;
          other_all_le  = 1'b1;
          other_some_lt = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input vvu_pkg::clock_t got,
                                 input vvu_pkg::clock_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    num_errors++;
  endtask

  task automatic send_req(input vvu_pkg::cmd_e cmd, input vvu_pkg::index_t idx,
                          input vvu_pkg::clock_t val, input logic last);
    int unsigned gap;
    if (req_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.device_index <= idx;
    req.clock_value  <= val;
    req.last         <= last;
    do @(posedge clk_i); while (!req.ready);
    vector_clock_step(cmd, idx, val, last);
    num_requests++;
  endtask

  task automatic wait_results_done();
    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic vvu_pkg::clock_t rand_clock();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return vvu_pkg::clock_t'($urandom_range(0, 20));
      3: return 64'h8000_0000_0000_0000 ^ vvu_pkg::clock_t'($urandom_range(0, 3));
      4: return '1 - vvu_pkg::clock_t'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic vvu_pkg::clock_t near_clock(vvu_pkg::index_t idx);
    case ($urandom_range(0, 4))
      0, 1: return shadow_clock[idx];
      2: return shadow_clock[idx] + 64'd1;
      3: return shadow_clock[idx] - 64'd1;
      default: return rand_clock();
    endcase
  endfunction

  // full in-order compare run; mode picks how the other vector relates
  task automatic sweep_compare(input int unsigned mode);
    vvu_pkg::clock_t vals [NUM_DEV];
    vvu_pkg::clock_t base;
    for (int i = 0; i < NUM_DEV; i++) begin
      base = shadow_clock[i];
      case (mode)
        0: vals[i] = base;
        1: vals[i] = (base != '1 && $urandom_range(0, 3) == 0) ? base + 64'd1 : base;
        2: vals[i] = (base != '0 && $urandom_range(0, 3) == 0) ? base - 64'd1 : base;
        3: vals[i] = near_clock(vvu_pkg::index_t'(i));
        default: vals[i] = rand_clock();
      endcase
    end
    for (int i = 0; i < NUM_DEV; i++)
      send_req(vvu_pkg::CMD_COMPARE, vvu_pkg::index_t'(i), vals[i], i == NUM_DEV - 1);
  endtask

  // short run with random order, table writes in between, stray last flags
  task automatic broken_compare_run();
    int unsigned     len;
    vvu_pkg::index_t idx;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      idx = vvu_pkg::index_t'($urandom_range(0, NUM_DEV - 1));
      case ($urandom_range(0, 5))
        0: send_req(vvu_pkg::cmd_e'($urandom_range(0, 1)), idx, near_clock(idx),
                    1'($urandom_range(0, 1)));
        1: send_req(vvu_pkg::CMD_READ, idx, rand_clock(), 1'b1);
        default: send_req(vvu_pkg::CMD_COMPARE, idx, near_clock(idx),
                          k == len - 1 && $urandom_range(0, 4) != 0);
      endcase
    end
  endtask

  task automatic test_counter_ops();
    send_req(vvu_pkg::CMD_READ, 4'd0, '0, 1'b0);
    send_req(vvu_pkg::CMD_UPDATE, 4'd3, '1, 1'b0);
    send_req(vvu_pkg::CMD_INCREMENT, 4'd3, '0, 1'b0);
    send_req(vvu_pkg::CMD_READ, 4'd3, '1, 1'b0);
    send_req(vvu_pkg::CMD_UPDATE, 4'd15, 64'd5, 1'b0);
    send_req(vvu_pkg::CMD_UPDATE, 4'd15, 64'd2, 1'b1);
    send_req(vvu_pkg::CMD_READ, 4'd15, '0, 1'b0);
    send_req(vvu_pkg::CMD_UPDATE, 4'd0, 64'h8000_0000_0000_0000, 1'b0);
    send_req(vvu_pkg::CMD_INCREMENT, 4'd0, '1, 1'b1);
    send_req(vvu_pkg::CMD_READ, 4'd0, '0, 1'b1);
  endtask

  task automatic test_compare_cases();
    // equal
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd5, 1'b1);
    // local before other
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd6, 1'b1);
    // local after other
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd4, 1'b0);
    send_req(vvu_pkg::CMD_COMPARE, 4'd3, 64'd0, 1'b1);
    // concurrent
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd6, 1'b0);
    send_req(vvu_pkg::CMD_COMPARE, 4'd0, 64'd0, 1'b1);
    // table changed mid-run
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd5, 1'b0);
    send_req(vvu_pkg::CMD_INCREMENT, 4'd15, '0, 1'b0);
    send_req(vvu_pkg::CMD_COMPARE, 4'd15, 64'd5, 1'b1);
    // repeated index
    send_req(vvu_pkg::CMD_COMPARE, 4'd3, 64'd0, 1'b0);
    send_req(vvu_pkg::CMD_COMPARE, 4'd3, 64'd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned target, input bit with_idle);
    int unsigned     pick;
    vvu_pkg::index_t idx;
    req_idle_en = with_idle;
    rsp_idle_en = with_idle;
    while (num_requests < target) begin
      if (with_idle && $urandom_range(0, 29) == 0) begin
        req_idle_en = $urandom_range(0, 2) != 0;
        rsp_idle_en = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 9);
      idx  = vvu_pkg::index_t'($urandom_range(0, NUM_DEV - 1));
      if (pick < 4) begin
        sweep_compare($urandom_range(0, 4));
      end else if (pick < 6) begin
        broken_compare_run();
      end else begin
        send_req(vvu_pkg::cmd_e'($urandom_range(0, 2)),
                 idx, $urandom_range(0, 1) ? near_clock(idx) : rand_clock(),
                 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    vvu_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none pending", rsp.read_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp.read_value !== want.read_value)
          report_mismatch("read_value", rsp.read_value, want.read_value);
        if (rsp.is_before !== want.is_before)
          report_mismatch("is_before", vvu_pkg::clock_t'(rsp.is_before),
                          vvu_pkg::clock_t'(want.is_before));
        if (rsp.is_after !== want.is_after)
          report_mismatch("is_after", vvu_pkg::clock_t'(rsp.is_after),
                          vvu_pkg::clock_t'(want.is_after));
        if (rsp.is_equal !== want.is_equal)
          report_mismatch("is_equal", vvu_pkg::clock_t'(rsp.is_equal),
                          vvu_pkg::clock_t'(want.is_equal));
      end
    end
  end

  // response back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_idle_en && stall_left == 0 && $urandom_range(0, 6) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("version_vector_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_DEV; i++) shadow_clock[i] = '0;
    local_all_le     = 1'b1;
    local_some_lt    = 1'b0;
    other_all_le     = 1'b1;
    other_some_lt    = 1'b0;
    num_requests     = 0;
    num_reads        = 0;
    num_before       = 0;
    num_after        = 0;
    num_equal        = 0;
    num_concurrent   = 0;
    req_idle_en      = 1'b1;
    rsp_idle_en      = 1'b1;
    rst_ni           = 1'b0;
    req.valid        <= 1'b0;
    req.command      <= vvu_pkg::CMD_UPDATE;
    req.device_index <= '0;
    req.clock_value  <= '0;
    req.last         <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_counter_ops();
    test_compare_cases();
    wait_results_done();
    test_random_traffic(800, 1'b1);
    wait_results_done();
    test_random_traffic(1150, 1'b0);
    wait_results_done();

    if (awaited_results.size() != 0)
      report_mismatch("results never returned",
                      vvu_pkg::clock_t'(awaited_results.size()), '0);
    $display("%0d requests sent, %0d reads; compares: %0d before, %0d after, %0d equal, %0d concurrent",
             num_requests, num_reads, num_before, num_after, num_equal, num_concurrent);
    $display("covered counter max/increment wrap, partial and full compare runs, idle bursts");
    if (num_errors == 0) begin
      $display("version_vector_unit test passed");
    end else begin
      $display("version_vector_unit test failed");
    end
    $finish;
  end

endmodule
